// ----- design/kxps_pkg.sv -----
`default_nettype none

package kxps_pkg;

  // Store geometry.
  localparam int NUM_PARTS  = 4;
  localparam int PART_BYTES = 1024;
  localparam int KEY_BYTES  = 8;

  // Fixed field widths of the request and response items.
  localparam int MODE_W   = 3;
  localparam int PNUM_W   = 3;
  localparam int UID_W    = 16;
  localparam int NSIZE_W  = 12;
  localparam int KEY_W    = 64;
  localparam int POS_W    = 12;
  localparam int WHENCE_W = 2;
  localparam int CPOS_W   = 10;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 4;
  localparam int NPOS_W   = 10;
  localparam int OWNER_W  = UID_W + 1;

  // Widths derived from the geometry.
  localparam int PART_IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int SIZE_W     = $clog2(PART_BYTES + 1);
  localparam int OFF_W      = (PART_BYTES > 1) ? $clog2(PART_BYTES) : 1;
  localparam int MEM_DEPTH  = NUM_PARTS * PART_BYTES;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int KIDX_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Offset modulo key length by reciprocal multiplication, exact for offsets below
  // 2**OFF_W.
  localparam int KEY_SHIFT = OFF_W + KIDX_W;
  localparam int RECIP_W   = KEY_SHIFT + 1;
  localparam logic [RECIP_W-1:0] KEY_RECIP =
    RECIP_W'(((2 ** KEY_SHIFT) + KEY_BYTES - 1) / KEY_BYTES);
  localparam int PROD_W = OFF_W + RECIP_W;

  // Owner value of a partition that nobody holds.
  localparam logic [OWNER_W-1:0] NO_OWNER = '1;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REKEY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEEK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd6;

  // Seek origins.
  localparam logic [WHENCE_W-1:0] WH_SET = 2'd0;
  localparam logic [WHENCE_W-1:0] WH_CUR = 2'd1;
  localparam logic [WHENCE_W-1:0] WH_END = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_NOPART     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BADSIZE    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NOTCREATED = 4'd4;
  localparam logic [STATUS_W-1:0] ST_DENIED     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BADWHENCE  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_END        = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BADMODE    = 4'd9;

  // Follow-up work that a decided command needs.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ACCESS
  } act_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic key;
    logic access;
    logic clear;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    act_t act;
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/kxps_req_if.sv -----
`default_nettype none

interface kxps_req_if;
  logic                               valid;
  logic                               ready;
  logic [kxps_pkg::MODE_W-1:0]        mode;
  logic [kxps_pkg::PNUM_W-1:0]        partition;
  logic [kxps_pkg::UID_W-1:0]         user_id;
  logic [kxps_pkg::NSIZE_W-1:0]       new_size;
  logic [kxps_pkg::KEY_W-1:0]         new_key;
  logic signed [kxps_pkg::POS_W-1:0]  position;
  logic [kxps_pkg::WHENCE_W-1:0]      whence;
  logic [kxps_pkg::CPOS_W-1:0]        current_pos;
  logic [kxps_pkg::DATA_W-1:0]        data_in;

  modport source (
    output valid, mode, partition, user_id, new_size, new_key, position, whence,
           current_pos, data_in,
    input  ready
  );

  modport sink (
    input  valid, mode, partition, user_id, new_size, new_key, position, whence,
           current_pos, data_in,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/kxps_rsp_if.sv -----
`default_nettype none

interface kxps_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [kxps_pkg::STATUS_W-1:0]  status;
  logic [kxps_pkg::DATA_W-1:0]    data_out;
  logic [kxps_pkg::NPOS_W-1:0]    new_position;

  modport source (
    output valid, status, data_out, new_position,
    input  ready
  );

  modport sink (
    input  valid, status, data_out, new_position,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/keyed_xor_partitioned_byte_store.sv -----
// A request passes the decision first. Seek, key change, delete and every error then go
// straight to the response; a byte read or write first forms the key index and reads memory,
// then writes memory or unmasks; create and erase first zero the partition one byte a
// cycle. One request is in flight at a time: a new request is taken only once the response
// of the last one has been registered. A waiting response does not block the next transfer
// in, but the next response waits behind it.
// Synchronous reset clears the controller and all partition descriptors; the byte
// memory is not cleared.
`default_nettype none

module keyed_xor_partitioned_byte_store (
  input  wire logic   clk,
  input  wire logic   rst,
  kxps_req_if.sink    req,
  kxps_rsp_if.source  rsp
);

  kxps_pkg::cmd_t cmd;
  kxps_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // Sequencing of one command.
  kxps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Descriptors, byte memory and result formation.
  kxps_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (req.mode),
    .partition    (req.partition),
    .user_id      (req.user_id),
    .new_size     (req.new_size),
    .new_key      (req.new_key),
    .position     (req.position),
    .whence       (req.whence),
    .current_pos  (req.current_pos),
    .data_in      (req.data_in),
    .status       (rsp.status),
    .data_out     (rsp.data_out),
    .new_position (rsp.new_position)
  );

endmodule

`default_nettype wire

// ----- design/kxps_ctrl.sv -----
`default_nettype none

module kxps_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output kxps_pkg::cmd_t      cmd,
  input  wire kxps_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_KEY,
    S_ACCESS,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Commands follow from the state, with load also gated by in_valid and emit by a free result register.
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.decide = (state == S_CHECK);
    cmd.key    = (state == S_KEY);
    cmd.access = (state == S_ACCESS);
    cmd.clear  = (state == S_CLEAR);
    cmd.emit   = (state == S_DONE) && out_free;
  end

  // State sequence and the response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (sts.act)
            kxps_pkg::ACT_CLEAR:  state <= S_CLEAR;
            kxps_pkg::ACT_ACCESS: state <= S_KEY;
            default:              state <= S_DONE;
          endcase
        end
        S_KEY: begin
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          state <= S_DONE;
        end
        S_CLEAR: begin
          if (sts.clear_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/kxps_dpath.sv -----
`default_nettype none

module kxps_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire kxps_pkg::cmd_t                     cmd,
  output kxps_pkg::sts_t                          sts,
  input  wire logic [kxps_pkg::MODE_W-1:0]        mode,
  input  wire logic [kxps_pkg::PNUM_W-1:0]        partition,
  input  wire logic [kxps_pkg::UID_W-1:0]         user_id,
  input  wire logic [kxps_pkg::NSIZE_W-1:0]       new_size,
  input  wire logic [kxps_pkg::KEY_W-1:0]         new_key,
  input  wire logic signed [kxps_pkg::POS_W-1:0]  position,
  input  wire logic [kxps_pkg::WHENCE_W-1:0]      whence,
  input  wire logic [kxps_pkg::CPOS_W-1:0]        current_pos,
  input  wire logic [kxps_pkg::DATA_W-1:0]        data_in,
  output logic [kxps_pkg::STATUS_W-1:0]           status,
  output logic [kxps_pkg::DATA_W-1:0]             data_out,
  output logic [kxps_pkg::NPOS_W-1:0]             new_position
);

  // Captured request.
  logic [kxps_pkg::MODE_W-1:0]        mode_q;
  logic [kxps_pkg::PNUM_W-1:0]        part_q;
  logic [kxps_pkg::UID_W-1:0]         uid_q;
  logic [kxps_pkg::NSIZE_W-1:0]       nsize_q;
  logic [kxps_pkg::KEY_W-1:0]         nkey_q;
  logic [kxps_pkg::POS_W-1:0]         pos_q;
  logic [kxps_pkg::WHENCE_W-1:0]      whence_q;
  logic [kxps_pkg::CPOS_W-1:0]        cur_q;
  logic [kxps_pkg::DATA_W-1:0]        din_q;

  // Per-partition descriptors.
  logic                               in_use     [kxps_pkg::NUM_PARTS];
  logic [kxps_pkg::SIZE_W-1:0]        part_size  [kxps_pkg::NUM_PARTS];
  logic [kxps_pkg::SIZE_W-1:0]        used_length[kxps_pkg::NUM_PARTS];
  logic [kxps_pkg::OWNER_W-1:0]       owner_id   [kxps_pkg::NUM_PARTS];
  logic [kxps_pkg::KEY_W-1:0]         key_store  [kxps_pkg::NUM_PARTS];

  // Byte store.
  logic [kxps_pkg::DATA_W-1:0]        byte_store [kxps_pkg::MEM_DEPTH];
  logic                               mem_we;
  logic [kxps_pkg::ADDR_W-1:0]        mem_waddr;
  logic [kxps_pkg::DATA_W-1:0]        mem_wdata;
  logic [kxps_pkg::DATA_W-1:0]        rd_q;

  // Working registers of one command.
  logic [kxps_pkg::ADDR_W-1:0]        base_q;
  logic [kxps_pkg::ADDR_W-1:0]        addr_q;
  logic [kxps_pkg::OFF_W-1:0]         off_q;
  logic [kxps_pkg::OFF_W-1:0]         quot_q;
  logic [kxps_pkg::OFF_W-1:0]         cnt;
  logic [kxps_pkg::DATA_W-1:0]        kbyte_q;
  logic [kxps_pkg::STATUS_W-1:0]      res_status;
  logic [kxps_pkg::DATA_W-1:0]        res_data;
  logic [kxps_pkg::NPOS_W-1:0]        res_npos;

  // Decision terms.
  logic                               pvalid;
  logic [kxps_pkg::PART_IDX_W-1:0]    pidx;
  logic                               use_p;
  logic [kxps_pkg::SIZE_W-1:0]        size_p;
  logic [kxps_pkg::SIZE_W-1:0]        used_p;
  logic [kxps_pkg::OWNER_W-1:0]       owner_p;
  logic signed [13:0]                 pos_x;
  logic signed [13:0]                 cur_x;
  logic signed [13:0]                 size_x;
  logic signed [13:0]                 tgt;
  logic [kxps_pkg::POS_W-2:0]         off_full;
  logic [kxps_pkg::SIZE_W-1:0]        lim;
  logic [kxps_pkg::SIZE_W-1:0]        used_next;
  logic [kxps_pkg::PROD_W-1:0]        prod;
  logic [kxps_pkg::OFF_W-1:0]         rem;
  logic [kxps_pkg::STATUS_W-1:0]      dec_status;
  logic [kxps_pkg::NPOS_W-1:0]        dec_npos;
  kxps_pkg::act_t                     dec_act;
  logic                               do_create;
  logic                               do_rekey;
  logic                               do_erase;
  logic                               do_delete;
  logic                               do_write;

  // Request capture on a transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      part_q   <= partition;
      uid_q    <= user_id;
      nsize_q  <= new_size;
      nkey_q   <= new_key;
      pos_q    <= position;
      whence_q <= whence;
      cur_q    <= current_pos;
      din_q    <= data_in;
    end
  end

  // Descriptor of the addressed partition.
  assign pvalid  = ({1'b0, part_q} < (kxps_pkg::PNUM_W + 1)'(kxps_pkg::NUM_PARTS));
  assign pidx    = part_q[kxps_pkg::PART_IDX_W-1:0];
  assign use_p   = pvalid && in_use[pidx];
  assign size_p  = part_size[pidx];
  assign used_p  = used_length[pidx];
  assign owner_p = owner_id[pidx];

  // Seek target arithmetic.
  assign pos_x  = 14'(signed'(pos_q));
  assign cur_x  = signed'(14'(cur_q));
  assign size_x = signed'(14'(size_p));
  always_comb begin
    case (whence_q)
      kxps_pkg::WH_SET: tgt = pos_x;
      kxps_pkg::WH_CUR: tgt = cur_x + pos_x;
      kxps_pkg::WH_END: tgt = size_x - 14'sd1 - pos_x;
      default:          tgt = 14'sd0;
    endcase
  end

  // Byte access offset and limit.
  assign off_full  = pos_q[kxps_pkg::POS_W-2:0];
  assign lim       = (mode_q == kxps_pkg::MODE_READ) ? used_p : size_p;
  assign used_next = kxps_pkg::SIZE_W'(12'(off_full) + 12'd1);

  // Command decision.
  always_comb begin
    dec_status = kxps_pkg::ST_OK;
    dec_npos   = '0;
    dec_act    = kxps_pkg::ACT_NONE;
    do_create  = 1'b0;
    do_rekey   = 1'b0;
    do_erase   = 1'b0;
    do_delete  = 1'b0;
    do_write   = 1'b0;
    if (!pvalid) begin
      dec_status = kxps_pkg::ST_NOPART;
    end else if (mode_q > kxps_pkg::MODE_WRITE) begin
      dec_status = kxps_pkg::ST_BADMODE;
    end else if (mode_q == kxps_pkg::MODE_CREATE) begin
      if (use_p) begin
        dec_status = kxps_pkg::ST_EXISTS;
      end else if (nsize_q == '0 ||
                   13'(nsize_q) > 13'(kxps_pkg::PART_BYTES)) begin
        dec_status = kxps_pkg::ST_BADSIZE;
      end else begin
        do_create = 1'b1;
        dec_act   = kxps_pkg::ACT_CLEAR;
      end
    end else if (!use_p) begin
      dec_status = kxps_pkg::ST_NOTCREATED;
    end else if (owner_p != {1'b0, uid_q}) begin
      dec_status = kxps_pkg::ST_DENIED;
    end else if (mode_q == kxps_pkg::MODE_REKEY) begin
      do_rekey = 1'b1;
    end else if (mode_q == kxps_pkg::MODE_ERASE) begin
      do_erase = 1'b1;
      dec_act  = kxps_pkg::ACT_CLEAR;
    end else if (mode_q == kxps_pkg::MODE_DELETE) begin
      do_delete = 1'b1;
    end else if (mode_q == kxps_pkg::MODE_SEEK) begin
      if (whence_q != kxps_pkg::WH_SET && whence_q != kxps_pkg::WH_CUR &&
          whence_q != kxps_pkg::WH_END) begin
        dec_status = kxps_pkg::ST_BADWHENCE;
      end else if (tgt < 14'sd0 || tgt >= size_x) begin
        dec_status = kxps_pkg::ST_RANGE;
      end else begin
        dec_npos = tgt[kxps_pkg::NPOS_W-1:0];
      end
    end else begin
      if (pos_q[kxps_pkg::POS_W-1]) begin
        dec_status = kxps_pkg::ST_RANGE;
      end else if (12'(off_full) >= 12'(lim) ||
                   12'(off_full) >= 12'(kxps_pkg::PART_BYTES)) begin
        dec_status = kxps_pkg::ST_END;
      end else begin
        dec_npos = kxps_pkg::NPOS_W'(12'(off_full) + 12'd1);
        dec_act  = kxps_pkg::ACT_ACCESS;
        do_write = (mode_q == kxps_pkg::MODE_WRITE);
      end
    end
  end

  assign sts.act        = dec_act;
  assign sts.clear_last = (cnt == kxps_pkg::OFF_W'(kxps_pkg::PART_BYTES - 1));

  // Descriptor updates, applied when the command is decided.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kxps_pkg::NUM_PARTS; i++) begin
        in_use[i]      <= 1'b0;
        part_size[i]   <= '0;
        used_length[i] <= '0;
        owner_id[i]    <= kxps_pkg::NO_OWNER;
        key_store[i]   <= '0;
      end
    end else if (cmd.decide) begin
      if (do_create) begin
        in_use[pidx]      <= 1'b1;
        part_size[pidx]   <= kxps_pkg::SIZE_W'(nsize_q);
        used_length[pidx] <= '0;
        owner_id[pidx]    <= {1'b0, uid_q};
        key_store[pidx]   <= nkey_q;
      end
      if (do_rekey) begin
        key_store[pidx] <= nkey_q;
      end
      if (do_erase) begin
        used_length[pidx] <= '0;
      end
      if (do_delete) begin
        in_use[pidx]      <= 1'b0;
        part_size[pidx]   <= '0;
        used_length[pidx] <= '0;
        owner_id[pidx]    <= kxps_pkg::NO_OWNER;
      end
      if (do_write && used_next > used_p) begin
        used_length[pidx] <= used_next;
      end
    end
  end

  // Quotient of the offset by the key length, via the reciprocal.
  assign prod = kxps_pkg::PROD_W'(off_full[kxps_pkg::OFF_W-1:0]) *
                kxps_pkg::PROD_W'(kxps_pkg::KEY_RECIP);
  assign rem  = off_q - kxps_pkg::OFF_W'(quot_q * kxps_pkg::OFF_W'(kxps_pkg::KEY_BYTES));

  // Working registers and result of the decided command.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      base_q     <= kxps_pkg::ADDR_W'(pidx) * kxps_pkg::ADDR_W'(kxps_pkg::PART_BYTES);
      addr_q     <= kxps_pkg::ADDR_W'(kxps_pkg::ADDR_W'(pidx) *
                                      kxps_pkg::ADDR_W'(kxps_pkg::PART_BYTES) +
                                      kxps_pkg::ADDR_W'(off_full[kxps_pkg::OFF_W-1:0]));
      off_q      <= off_full[kxps_pkg::OFF_W-1:0];
      quot_q     <= kxps_pkg::OFF_W'(prod >> kxps_pkg::KEY_SHIFT);
      cnt        <= '0;
      res_status <= dec_status;
      res_npos   <= dec_npos;
      res_data   <= '0;
    end else if (cmd.clear) begin
      cnt <= cnt + kxps_pkg::OFF_W'(1);
    end else if (cmd.access && mode_q == kxps_pkg::MODE_READ) begin
      res_data <= rd_q ^ kbyte_q;
    end
    if (cmd.key) begin
      kbyte_q <= key_store[pidx][8 * rem[kxps_pkg::KIDX_W-1:0] +: 8];
    end
  end

  // Single write port: clearing sweep or a byte write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = din_q ^ kbyte_q;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = base_q + kxps_pkg::ADDR_W'(cnt);
      mem_wdata = '0;
    end else if (cmd.access && mode_q == kxps_pkg::MODE_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read, issued while the key byte is formed.
  always_ff @(posedge clk) begin
    if (cmd.key) begin
      rd_q <= byte_store[addr_q];
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= res_status;
      data_out     <= res_data;
      new_position <= res_npos;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/kxps_store_checker.sv -----
`timescale 1ns / 1ps

module kxps_store_checker (
  input  logic clk,
  input  logic rst,
  kxps_req_if  req,
  kxps_rsp_if  rsp,
  output int   mismatches,
  output int   in_flight
);
  import kxps_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [NPOS_W-1:0]   new_position;
  } reply_t;

  // Shadow copy of the partitions: ciphered bytes and per-partition descriptors.
  logic [DATA_W-1:0]  shadow_mem [MEM_DEPTH];
  logic               part_live  [NUM_PARTS];
  int                 part_len   [NUM_PARTS];
  int                 part_fill  [NUM_PARTS];
  logic [OWNER_W-1:0] part_owner [NUM_PARTS];
  logic [KEY_W-1:0]   part_key   [NUM_PARTS];

  // Replies owed by the block, oldest first.
  reply_t pending_replies [$];
  int     fail_total = 0;

  assign mismatches = fail_total;

  function automatic void wipe_partition(int p);
    for (int i = 0; i < PART_BYTES; i++) begin
      shadow_mem[p * PART_BYTES + i] = '0;
    end
  endfunction

  // Applies one command to the shadow state and returns the reply it earns.
  function automatic reply_t apply_request(
    logic [MODE_W-1:0]   mode,
    logic [PNUM_W-1:0]   pnum,
    logic [UID_W-1:0]    uid,
    logic [NSIZE_W-1:0]  nsize,
    logic [KEY_W-1:0]    nkey,
    logic [POS_W-1:0]    praw,
    logic [WHENCE_W-1:0] whence,
    logic [CPOS_W-1:0]   cur,
    logic [DATA_W-1:0]   din
  );
    reply_t             r;
    int                 p;
    int                 pos;
    int                 target;
    int                 lim;
    logic               good_whence;
    logic [DATA_W-1:0]  kb;
    r = '0;
    p = pnum;
    pos = $signed(praw);
    target = 0;
    good_whence = 1'b1;

    if (pnum >= NUM_PARTS) begin
      r.status = ST_NOPART;
    end else if (mode > MODE_WRITE) begin
      r.status = ST_BADMODE;
    end else if (mode == MODE_CREATE) begin
      // Create needs a free partition and a legal size; ownership is not checked.
      if (part_live[p]) begin
        r.status = ST_EXISTS;
      end else if (nsize == 0 || nsize > PART_BYTES) begin
        r.status = ST_BADSIZE;
      end else begin
        part_live[p]  = 1'b1;
        part_len[p]   = nsize;
        part_fill[p]  = 0;
        part_owner[p] = {1'b0, uid};
        part_key[p]   = nkey;
        wipe_partition(p);
      end
    end else if (!part_live[p]) begin
      r.status = ST_NOTCREATED;
    end else if (part_owner[p] != {1'b0, uid}) begin
      r.status = ST_DENIED;
    end else begin
      case (mode)
        MODE_REKEY: begin
          part_key[p] = nkey;
        end
        MODE_ERASE: begin
          part_fill[p] = 0;
          wipe_partition(p);
        end
        MODE_DELETE: begin
          // The key survives a delete.
          part_live[p]  = 1'b0;
          part_len[p]   = 0;
          part_fill[p]  = 0;
          part_owner[p] = NO_OWNER;
        end
        MODE_SEEK: begin
          case (whence)
            WH_SET:  target = pos;
            WH_CUR:  target = int'(cur) + pos;
            WH_END:  target = part_len[p] - 1 - pos;
            default: good_whence = 1'b0;
          endcase
          if (!good_whence) begin
            r.status = ST_BADWHENCE;
          end else if (target < 0 || target >= part_len[p]) begin
            r.status = ST_RANGE;
          end else begin
            r.new_position = NPOS_W'(target);
          end
        end
        MODE_READ, MODE_WRITE: begin
          // Reads stop at the used length, writes at the partition size.
          lim = (mode == MODE_READ) ? part_fill[p] : part_len[p];
          if (pos < 0) begin
            r.status = ST_RANGE;
          end else if (pos >= lim || pos >= PART_BYTES) begin
            r.status = ST_END;
          end else begin
            kb = part_key[p][(pos % KEY_BYTES) * 8 +: 8];
            if (mode == MODE_READ) begin
              r.data_out = shadow_mem[p * PART_BYTES + pos] ^ kb;
            end else begin
              shadow_mem[p * PART_BYTES + pos] = din ^ kb;
              if (pos + 1 > part_fill[p]) part_fill[p] = pos + 1;
            end
            r.new_position = NPOS_W'(pos + 1);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Watch both channels; responses are matched before new requests are queued.
  always @(posedge clk) begin : watch_channels
    reply_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_live[i]  = 1'b0;
        part_len[i]   = 0;
        part_fill[i]  = 0;
        part_owner[i] = NO_OWNER;
        part_key[i]   = '0;
      end
      pending_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_replies.size() == 0) begin
          $error("response transfer with no request outstanding: status %0d", rsp.status);
          fail_total++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            fail_total++;
          end
          if (rsp.data_out !== want.data_out) begin
            $error("data_out mismatch: expected %0h, got %0h", want.data_out, rsp.data_out);
            fail_total++;
          end
          if (rsp.new_position !== want.new_position) begin
            $error("new_position mismatch: expected %0d, got %0d",
                   want.new_position, rsp.new_position);
            fail_total++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_replies.push_back(apply_request(req.mode, req.partition, req.user_id,
                                                req.new_size, req.new_key, req.position,
                                                req.whence, req.current_pos, req.data_in));
      end
    end
    in_flight <= pending_replies.size();
  end

endmodule

// ----- tb/sv/tb_keyed_xor_partitioned_byte_store.sv -----
`timescale 1ns / 1ps

module tb_keyed_xor_partitioned_byte_store;
  import kxps_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 5_000_000;

  // Codes the package leaves unnamed.
  localparam logic [MODE_W-1:0]   MODE_UNUSED = MODE_W'(MODE_WRITE + 1);
  localparam logic [WHENCE_W-1:0] WH_BAD      = 2'd3;

  localparam logic [UID_W-1:0] UID_HIGH = '1;
  localparam logic [UID_W-1:0] UID_LOW  = '0;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [PNUM_W-1:0]   partition;
    logic [UID_W-1:0]    user_id;
    logic [NSIZE_W-1:0]  new_size;
    logic [KEY_W-1:0]    new_key;
    logic [POS_W-1:0]    position;
    logic [WHENCE_W-1:0] whence;
    logic [CPOS_W-1:0]   current_pos;
    logic [DATA_W-1:0]   data_in;
  } store_req_t;

  typedef enum {RX_OPEN, RX_SPARSE, RX_HOLD, RX_TOGGLE} rx_pattern_t;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   in_flight;
  int   cycle_count = 0;
  int   burst_left;

  // Loose picture of each partition, used only to steer the stimulus.
  logic             hint_live  [NUM_PARTS];
  int               hint_len   [NUM_PARTS];
  int               hint_fill  [NUM_PARTS];
  logic [UID_W-1:0] hint_owner [NUM_PARTS];

  kxps_req_if req_ch ();
  kxps_rsp_if rsp_ch ();

  keyed_xor_partitioned_byte_store u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kxps_store_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_keyed_xor_partitioned_byte_store failed");
      $finish;
    end
  end

  // Response side: segments of open, sparse, held and toggling ready.
  initial begin : receiver
    rx_pattern_t pattern;
    int          seg_left;
    rsp_ch.ready <= 1'b0;
    pattern = RX_OPEN;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        seg_left = $urandom_range(1, 40);
      end
      seg_left--;
      case (pattern)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HOLD:   rsp_ch.ready <= 1'b0;
        default:   rsp_ch.ready <= ~rsp_ch.ready;
      endcase
    end
  end

  function automatic store_req_t fresh_req(logic [MODE_W-1:0] mode, int p,
                                           logic [UID_W-1:0] uid);
    store_req_t r;
    r.mode        = mode;
    r.partition   = PNUM_W'(p);
    r.user_id     = uid;
    r.new_size    = NSIZE_W'($urandom);
    r.new_key     = {$urandom, $urandom};
    r.position    = POS_W'($urandom);
    r.whence      = WHENCE_W'($urandom);
    r.current_pos = CPOS_W'($urandom);
    r.data_in     = DATA_W'($urandom);
    return r;
  endfunction

  // Drives one request until it transfers, then idles when the burst runs out.
  task automatic issue(input store_req_t r);
    int   p;
    int   off;
    logic owned;
    if (r.partition < NUM_PARTS) begin
      p = r.partition;
      off = $signed(r.position);
      owned = hint_live[p] && hint_owner[p] == r.user_id;
      case (r.mode)
        MODE_CREATE: begin
          if (!hint_live[p] && r.new_size != 0 && r.new_size <= PART_BYTES) begin
            hint_live[p]  = 1'b1;
            hint_len[p]   = r.new_size;
            hint_fill[p]  = 0;
            hint_owner[p] = r.user_id;
          end
        end
        MODE_ERASE:  if (owned) hint_fill[p] = 0;
        MODE_DELETE: if (owned) hint_live[p] = 1'b0;
        MODE_WRITE: begin
          if (owned && off >= 0 && off < hint_len[p] && off + 1 > hint_fill[p])
            hint_fill[p] = off + 1;
        end
        default: ;
      endcase
    end

    req_ch.valid       <= 1'b1;
    req_ch.mode        <= r.mode;
    req_ch.partition   <= r.partition;
    req_ch.user_id     <= r.user_id;
    req_ch.new_size    <= r.new_size;
    req_ch.new_key     <= r.new_key;
    req_ch.position    <= r.position;
    req_ch.whence      <= r.whence;
    req_ch.current_pos <= r.current_pos;
    req_ch.data_in     <= r.data_in;
    do @(posedge clk); while (!req_ch.ready);

    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Holds off the sender until every outstanding response has transferred.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    store_req_t r;
    int         p;
    int         roll;
    int         pick;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= '0;
    req_ch.partition   <= '0;
    req_ch.user_id     <= '0;
    req_ch.new_size    <= '0;
    req_ch.new_key     <= '0;
    req_ch.position    <= '0;
    req_ch.whence      <= '0;
    req_ch.current_pos <= '0;
    req_ch.data_in     <= '0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      hint_live[i]  = 1'b0;
      hint_len[i]   = 0;
      hint_fill[i]  = 0;
      hint_owner[i] = UID_W'($urandom);
    end
    burst_left = $urandom_range(1, 30);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: error paths first, then a full-size partition through its life.
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    issue(r);
    r = fresh_req(MODE_CREATE, 7, UID_HIGH);
    issue(r);
    r = fresh_req(MODE_UNUSED, 0, UID_HIGH);
    issue(r);
    r = fresh_req(MODE_CREATE, 0, UID_HIGH);
    r.new_size = '0;
    issue(r);
    r = fresh_req(MODE_CREATE, 0, UID_HIGH);
    r.new_size = '1;
    issue(r);
    r = fresh_req(MODE_CREATE, 0, UID_HIGH);
    r.new_size = NSIZE_W'(PART_BYTES);
    issue(r);
    r = fresh_req(MODE_CREATE, 0, UID_LOW);
    issue(r);
    r = fresh_req(MODE_WRITE, 0, UID_HIGH);
    r.position = '0;
    r.data_in = '1;
    issue(r);
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    r.position = '0;
    issue(r);
    // Read just past the used length.
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    r.position = 12'd1;
    issue(r);
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    r.position = '1;
    issue(r);
    // Last byte: the returned position wraps to zero.
    r = fresh_req(MODE_WRITE, 0, UID_HIGH);
    r.position = 12'd1023;
    r.data_in = '0;
    issue(r);
    r = fresh_req(MODE_WRITE, 0, UID_HIGH);
    r.position = 12'd1024;
    issue(r);
    r = fresh_req(MODE_WRITE, 0, UID_HIGH);
    r.position = 12'h800;
    issue(r);
    r = fresh_req(MODE_SEEK, 0, UID_HIGH);
    r.whence = WH_SET;
    r.position = 12'h7FF;
    issue(r);
    r = fresh_req(MODE_SEEK, 0, UID_HIGH);
    r.whence = WH_CUR;
    r.current_pos = '1;
    r.position = '0;
    issue(r);
    r = fresh_req(MODE_SEEK, 0, UID_HIGH);
    r.whence = WH_END;
    r.position = '1;
    issue(r);
    r = fresh_req(MODE_SEEK, 0, UID_HIGH);
    r.whence = WH_BAD;
    issue(r);
    r = fresh_req(MODE_REKEY, 0, UID_HIGH);
    issue(r);
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    r.position = '0;
    issue(r);
    r = fresh_req(MODE_ERASE, 0, UID_HIGH);
    issue(r);
    r = fresh_req(MODE_READ, 0, UID_HIGH);
    r.position = '0;
    issue(r);
    r = fresh_req(MODE_DELETE, 0, UID_LOW);
    issue(r);
    r = fresh_req(MODE_DELETE, 0, UID_HIGH);
    issue(r);
    // Smallest partition: the second byte is already beyond its size.
    r = fresh_req(MODE_CREATE, 3, UID_LOW);
    r.new_size = 12'd1;
    issue(r);
    r = fresh_req(MODE_WRITE, 3, UID_LOW);
    r.position = 12'd1;
    issue(r);
    drain();

    // Random: mostly owner traffic on live partitions, with some noise mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      p = $urandom_range(0, NUM_PARTS - 1);
      r = fresh_req(MODE_READ, p, hint_owner[p]);
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 8) begin
        r.mode      = MODE_W'($urandom);
        r.partition = PNUM_W'($urandom);
        r.user_id   = UID_W'($urandom);
      end else if (!hint_live[p]) begin
        r.mode = MODE_CREATE;
        r.user_id = UID_W'($urandom);
        if (pick < 70)      r.new_size = NSIZE_W'($urandom_range(1, 48));
        else if (pick < 82) r.new_size = NSIZE_W'(PART_BYTES);
        else if (pick < 92) r.new_size = NSIZE_W'($urandom_range(49, PART_BYTES - 1));
        else if (pick < 96) r.new_size = '0;
        else                r.new_size = NSIZE_W'($urandom_range(PART_BYTES + 1, 4095));
      end else begin
        if ($urandom_range(0, 19) == 0) r.user_id = UID_W'($urandom);
        if (pick < 35) begin
          r.mode = MODE_WRITE;
          if ($urandom_range(0, 9) != 0)
            r.position = POS_W'($urandom_range(0, hint_len[p]));
        end else if (pick < 66) begin
          r.mode = MODE_READ;
          if (hint_fill[p] > 0 && $urandom_range(0, 9) < 8)
            r.position = POS_W'($urandom_range(0, hint_fill[p] - 1));
          else if ($urandom_range(0, 9) != 0)
            r.position = POS_W'($urandom_range(0, hint_len[p]));
        end else if (pick < 81) begin
          r.mode = MODE_SEEK;
          if ($urandom_range(0, 9) < 8) begin
            r.position = POS_W'($urandom_range(0, 2 * hint_len[p]) - hint_len[p]);
            r.current_pos = CPOS_W'($urandom_range(0, hint_len[p] - 1));
          end
        end else if (pick < 86) begin
          r.mode = MODE_REKEY;
        end else if (pick < 89) begin
          r.mode = MODE_ERASE;
        end else if (pick < 95) begin
          r.mode = MODE_DELETE;
        end else if (pick < 98) begin
          r.mode = MODE_CREATE;
        end else begin
          r.mode = MODE_UNUSED;
        end
      end
      issue(r);
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (PART_BYTES + 8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_keyed_xor_partitioned_byte_store passed");
    end else begin
      $display("tb_keyed_xor_partitioned_byte_store failed");
    end
    $finish;
  end

endmodule
